[design/assert_macros.svh]
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// implication whose consequence is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[design/mttp_pkg.sv]
// Types and constants of the MIDI track timing parser
package mttp_pkg;
   localparam logic [1:0] KIND_TEMPO = 2'd0;
   localparam logic [1:0] KIND_METER = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;
   localparam logic [1:0] KIND_EOT   = 2'd3;

   localparam logic [2:0] ERR_DELTA    = 3'd0;
   localparam logic [2:0] ERR_RUNNING  = 3'd1;
   localparam logic [2:0] ERR_META_INC = 3'd2;
   localparam logic [2:0] ERR_META_LEN = 3'd3;
   localparam logic [2:0] ERR_SYSEX    = 3'd4;
   localparam logic [2:0] ERR_CHANNEL  = 3'd5;

   localparam logic [33:0] BPM_NUMER = 34'd15360000000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] tick;
      logic [23:0] tempo_us;
      logic [33:0] bpm_fixed;
      logic [7:0]  numerator;
      logic [10:0] denominator;
      logic [2:0]  error_code;
   } result_type;
endpackage

[design/midi_track_timing_parser_top.sv]
// Top level: MIDI track parser reporting tempo, meter, end of track and errors
// A byte that causes no result is taken while ready is high; a result is
// shown in the cycle after its byte, a tempo result once the divider, one
// quotient bit a cycle, is done. Ready drops while a result waits or divides.
// Reset (synchronous, active high) clears phase, tick, running status and
// flags; after an error no further result appears until reset.
module midi_track_timing_parser_top
   import mttp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // first_of_track
   input  logic         req_tlast,   // last_of_track
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: tick[31:0], tempo_us[55:32], bpm_fixed[89:56],
   // numerator[97:90], denominator[108:98], error_code[111:109], zero fill
   output logic [119:0] rsp_tdata,
   output logic [1:0]   rsp_tuser    // kind
);
`include "assert_macros.svh"
   localparam logic [3:0] PH_DELTA = 4'd0, PH_STATUS = 4'd1, PH_META_TYPE = 4'd2,
      PH_META_LEN = 4'd3, PH_META_DATA = 4'd4, PH_SYSEX_LEN = 4'd5,
      PH_SYSEX_DATA = 4'd6, PH_CHAN_DATA = 4'd7;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  rs_ff, rs_in, mk_ff, mk_in;
   logic [31:0] tick_ff, tick_in;
   logic [27:0] acc_ff, acc_in, rem_ff, rem_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [23:0] cap_ff, cap_in;
   logic        stop_ff, stop_in, err_ff, err_in;
   logic        ovalid_ff, ovalid_in, wdiv_ff, wdiv_in;
   result_type  res_ff, res_in;

   logic        div_start, div_busy, div_done;
   logic [33:0] div_q;

   mttp_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .divisor(res_in.tempo_us),
      .busy(div_busy), .done(div_done), .quotient(div_q)
   );

   assign req_tready = !ovalid_ff && !wdiv_ff;
   logic take;
   assign take = req_tvalid && req_tready;

   always_comb begin
      logic [7:0]  b;
      logic        fin, emit, vlq_ok, vlq_long;
      logic [27:0] vacc, idx;
      logic [2:0]  ecode;
      logic        eh;
      b = req_tdata;
      phase_in = phase_ff; rs_in = rs_ff; mk_in = mk_ff; tick_in = tick_ff;
      acc_in = acc_ff; rem_in = rem_ff; cnt_in = cnt_ff; cap_in = cap_ff;
      stop_in = stop_ff; err_in = err_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      wdiv_in = wdiv_ff; res_in = res_ff; div_start = 1'b0;
      fin = 1'b0; emit = 1'b0; eh = 1'b0; ecode = ERR_DELTA;
      vacc = 28'd0; idx = 28'd0; vlq_ok = 1'b0; vlq_long = 1'b0;
      if (div_done && wdiv_ff) begin
         res_in.bpm_fixed = div_q;
         wdiv_in = 1'b0;
         ovalid_in = 1'b1;
      end
      if (take && !err_ff) begin
         if (req_tuser) begin
            phase_in = PH_DELTA; rs_in = 8'd0; tick_in = 32'd0; acc_in = 28'd0;
            cnt_in = 2'd0; rem_in = 28'd0; cap_in = 24'd0; stop_in = 1'b0;
         end
         vacc = {acc_in[20:0], b[6:0]};
         vlq_ok = !b[7];
         vlq_long = b[7] && (cnt_in == 2'd3);
         if (!stop_in) begin
            unique case (phase_in)
               PH_DELTA, PH_META_LEN, PH_SYSEX_LEN: begin
                  acc_in = vacc;
                  if (vlq_ok) cnt_in = 2'd0;
                  else if (!vlq_long) cnt_in = cnt_in + 2'd1;
                  if (vlq_long) begin
                     eh = 1'b1;
                     ecode = (phase_in == PH_DELTA) ? ERR_DELTA :
                             (phase_in == PH_META_LEN) ? ERR_META_LEN : ERR_SYSEX;
                  end else if (vlq_ok) begin
                     if (phase_in == PH_DELTA) begin
                        tick_in = tick_in + {4'd0, vacc};
                        acc_in = 28'd0;
                        phase_in = PH_STATUS;
                     end else if (phase_in == PH_META_LEN) begin
                        rem_in = vacc;
                        cap_in = 24'd0;
                        if (vacc == 28'd0) fin = 1'b1;
                        else phase_in = PH_META_DATA;
                     end else begin
                        rem_in = vacc;
                        acc_in = 28'd0;
                        phase_in = (vacc != 28'd0) ? PH_SYSEX_DATA : PH_DELTA;
                     end
                  end
               end
               PH_STATUS: begin
                  if (!b[7]) begin
                     if (rs_in == 8'd0) begin
                        eh = 1'b1; ecode = ERR_RUNNING;
                     end else begin
                        rem_in = (rs_in[7:4] == 4'hC || rs_in[7:4] == 4'hD) ? 28'd0 : 28'd1;
                        phase_in = (rem_in != 28'd0) ? PH_CHAN_DATA : PH_DELTA;
                     end
                  end else if (b < 8'hF0) begin
                     rs_in = b;
                     rem_in = (b[7:4] == 4'hC || b[7:4] == 4'hD) ? 28'd1 : 28'd2;
                     phase_in = PH_CHAN_DATA;
                  end else if (b == 8'hFF) begin
                     phase_in = PH_META_TYPE;
                  end else if (b == 8'hF0 || b == 8'hF7) begin
                     rs_in = 8'd0; acc_in = 28'd0; cnt_in = 2'd0;
                     phase_in = PH_SYSEX_LEN;
                  end else begin
                     eh = 1'b1; ecode = ERR_CHANNEL;
                  end
               end
               PH_META_TYPE: begin
                  mk_in = b; acc_in = 28'd0; cnt_in = 2'd0;
                  phase_in = PH_META_LEN;
               end
               PH_META_DATA: begin
                  idx = acc_in - rem_in;
                  if (idx == 28'd0) cap_in[23:16] = cap_in[23:16] | b;
                  else if (idx == 28'd1) cap_in[15:8] = cap_in[15:8] | b;
                  else if (idx == 28'd2) cap_in[7:0] = cap_in[7:0] | b;
                  rem_in = rem_in - 28'd1;
                  if (rem_in == 28'd0) fin = 1'b1;
               end
               PH_SYSEX_DATA, PH_CHAN_DATA: begin
                  rem_in = rem_in - 28'd1;
                  if (rem_in == 28'd0) phase_in = PH_DELTA;
               end
               default: phase_in = PH_DELTA;
            endcase
            if (fin) begin
               res_in = '0;
               res_in.tick = tick_in;
               if (mk_in == 8'h51 && acc_in == 28'd3 && cap_in != 24'd0) begin
                  res_in.kind = KIND_TEMPO;
                  res_in.tempo_us = cap_in;
                  div_start = 1'b1;
               end else if (mk_in == 8'h58 && acc_in >= 28'd2) begin
                  if (cap_in[23:16] != 8'd0 && cap_in[15:8] <= 8'd10) begin
                     res_in.kind = KIND_METER;
                     res_in.numerator = cap_in[23:16];
                     res_in.denominator = 11'd1 << cap_in[11:8];
                     emit = 1'b1;
                  end
               end else if (mk_in == 8'h2F) begin
                  res_in.kind = KIND_EOT;
                  stop_in = 1'b1;
                  emit = 1'b1;
               end
               phase_in = PH_DELTA; acc_in = 28'd0; cnt_in = 2'd0; rem_in = 28'd0;
            end
            if (!eh && req_tlast && !stop_in) begin
               case (phase_in)
                  PH_DELTA: if (cnt_in != 2'd0) begin eh = 1'b1; ecode = ERR_DELTA; end
                  PH_META_TYPE: begin eh = 1'b1; ecode = ERR_META_INC; end
                  PH_META_LEN, PH_META_DATA: begin eh = 1'b1; ecode = ERR_META_LEN; end
                  PH_SYSEX_LEN, PH_SYSEX_DATA: begin eh = 1'b1; ecode = ERR_SYSEX; end
                  PH_CHAN_DATA: begin eh = 1'b1; ecode = ERR_CHANNEL; end
                  default: ;
               endcase
            end
         end
         if (eh) begin
            // error overrides any event of this byte
            div_start = 1'b0;
            emit = 1'b1;
            err_in = 1'b1;
            res_in = '0;
            res_in.kind = KIND_ERROR;
            res_in.tick = tick_in;
            res_in.error_code = ecode;
         end else if (req_tlast) begin
            phase_in = PH_DELTA; rs_in = 8'd0; tick_in = 32'd0; acc_in = 28'd0;
            cnt_in = 2'd0; rem_in = 28'd0; cap_in = 24'd0; stop_in = 1'b0;
         end
         if (emit) ovalid_in = 1'b1;
         if (div_start) wdiv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DELTA; rs_ff <= 8'd0; mk_ff <= 8'd0; tick_ff <= 32'd0;
         acc_ff <= 28'd0; rem_ff <= 28'd0; cnt_ff <= 2'd0; cap_ff <= 24'd0;
         stop_ff <= 1'b0; err_ff <= 1'b0; ovalid_ff <= 1'b0; wdiv_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; rs_ff <= rs_in; mk_ff <= mk_in; tick_ff <= tick_in;
         acc_ff <= acc_in; rem_ff <= rem_in; cnt_ff <= cnt_in; cap_ff <= cap_in;
         stop_ff <= stop_in; err_ff <= err_in; ovalid_ff <= ovalid_in;
         wdiv_ff <= wdiv_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tdata  = {8'd0, res_ff.error_code, res_ff.denominator, res_ff.numerator,
                        res_ff.bpm_fixed, res_ff.tempo_us, res_ff.tick};

   `ASSERT_IMPL(a_no_take_busy, clock, reset, ovalid_ff || wdiv_ff, !req_tready,
      "input taken while result pending")
   `ASSERT_IMPL(a_div_pairs, clock, reset, wdiv_ff, div_busy || div_done,
      "waiting on divider that is idle")
   `ASSERT_NEXT(a_err_sticky, clock, reset, err_ff, err_ff, "error flag cleared")
endmodule

[design/mttp_divider.sv]
// Restoring divider, one quotient bit a cycle, for the tempo to BPM step
module mttp_divider
   import mttp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [33:0] quotient
);
   logic [5:0]  count_ff, count_in;
   logic [33:0] quot_ff, quot_in;
   logic [24:0] rem_ff, rem_in;
   logic [23:0] div_ff, div_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [24:0] trial;
   logic [25:0] diff;

   always_comb begin
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff[23:0], quot_ff[33]};
      diff     = {1'b0, trial} - {2'b0, div_ff};
      if (start) begin
         busy_in  = 1'b1;
         count_in = 6'd0;
         quot_in  = BPM_NUMER;
         rem_in   = 25'd0;
         div_in   = divisor;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract if it fits
         if (!diff[25]) begin
            rem_in  = diff[24:0];
            quot_in = {quot_ff[32:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[32:0], 1'b0};
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd33) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 6'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule

[sim/tb.sv]
// Self-checking testbench for the MIDI track timing parser
module tb
   import mttp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PH_DELTA = 0, PH_STATUS = 1, PH_META_TYPE = 2, PH_META_LEN = 3,
                  PH_META_DATA = 4, PH_SYSEX_LEN = 5, PH_SYSEX_DATA = 6, PH_CHAN_DATA = 7;
   localparam int CYCLE_LIMIT = 1000000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [7:0]   req_tdata = 0;
   logic         req_tuser = 0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   // tdata: tick, tempo_us, bpm_fixed, numerator, denominator, error_code
   logic [119:0] rsp_tdata;
   logic [1:0]   rsp_tuser;   // kind

   midi_track_timing_parser_top dut (.*);

   initial forever #10 clock = ~clock;

   // parser image
   int          ph;
   logic [7:0]  run_status, meta_code;
   logic [31:0] abs_tick;
   logic [27:0] len_acc, remain;
   logic [1:0]  len_cnt;
   logic [23:0] capture;
   bit          stopped, failed_track;

   result_type  expected_events[$];
   int          mismatches = 0, sent = 0, received = 0, cycles = 0;
   bit          quiet = 0, hold_rsp = 0;
   int          kind_seen[4];

   task automatic report(input string what);
      mismatches++;
      $display("error at %0t: %s", $realtime, what);
   endtask

   function automatic void clear_track();
      ph = PH_DELTA; run_status = 0; abs_tick = 0; len_acc = 0; len_cnt = 0;
      remain = 0; capture = 0; stopped = 0;
   endfunction

   function automatic int take_vlq(input logic [7:0] b);
      len_acc = {len_acc[20:0], b[6:0]};
      if (!b[7]) begin
         len_cnt = 0;
         return 1;
      end
      if (len_cnt == 3) return 2;
      len_cnt++;
      return 0;
   endfunction

   function automatic void close_meta(inout result_type r, inout bit got);
      logic [7:0] num, pw;
      num = capture[23:16];
      pw = capture[15:8];
      if (meta_code == 8'h51 && len_acc == 3 && capture != 0) begin
         r = '0; r.kind = KIND_TEMPO; r.tick = abs_tick; r.tempo_us = capture;
         r.bpm_fixed = 34'(64'd15360000000 / 64'(capture)); got = 1;
      end else if (meta_code == 8'h58 && len_acc >= 2) begin
         if (num > 0 && pw <= 10) begin
            r = '0; r.kind = KIND_METER; r.tick = abs_tick; r.numerator = num;
            r.denominator = 11'(1) << pw; got = 1;
         end
      end else if (meta_code == 8'h2F) begin
         r = '0; r.kind = KIND_EOT; r.tick = abs_tick; stopped = 1; got = 1;
      end
      ph = PH_DELTA; len_acc = 0; len_cnt = 0; remain = 0;
   endfunction

   function automatic void predict_byte(input logic [7:0] b, input bit first, input bit last);
      result_type r;
      bit got;
      int err, v;
      logic [27:0] idx;
      got = 0; err = -1; r = '0;
      if (failed_track) return;
      if (first) clear_track();
      if (!stopped) begin
         case (ph)
            PH_DELTA: begin
               v = take_vlq(b);
               if (v == 1) begin
                  abs_tick += 32'(len_acc); len_acc = 0; ph = PH_STATUS;
               end else if (v == 2) err = ERR_DELTA;
            end
            PH_STATUS: begin
               if (b < 8'h80) begin
                  if (run_status == 0) err = ERR_RUNNING;
                  else begin
                     remain = (run_status[7:4] inside {4'hC, 4'hD}) ? 0 : 1;
                     ph = remain ? PH_CHAN_DATA : PH_DELTA;
                  end
               end else if (b < 8'hF0) begin
                  run_status = b;
                  remain = (b[7:4] inside {4'hC, 4'hD}) ? 1 : 2;
                  ph = PH_CHAN_DATA;
               end else if (b == 8'hFF) ph = PH_META_TYPE;
               else if (b == 8'hF0 || b == 8'hF7) begin
                  run_status = 0; len_acc = 0; len_cnt = 0; ph = PH_SYSEX_LEN;
               end else err = ERR_CHANNEL;
            end
            PH_META_TYPE: begin
               meta_code = b; len_acc = 0; len_cnt = 0; ph = PH_META_LEN;
            end
            PH_META_LEN: begin
               v = take_vlq(b);
               if (v == 1) begin
                  remain = len_acc; capture = 0;
                  if (remain == 0) close_meta(r, got);
                  else ph = PH_META_DATA;
               end else if (v == 2) err = ERR_META_LEN;
            end
            PH_META_DATA: begin
               idx = len_acc - remain;
               if (idx < 3) capture |= 24'(b) << (16 - 8 * idx);
               remain = remain - 1;
               if (remain == 0) close_meta(r, got);
            end
            PH_SYSEX_LEN: begin
               v = take_vlq(b);
               if (v == 1) begin
                  remain = len_acc; len_acc = 0;
                  ph = remain ? PH_SYSEX_DATA : PH_DELTA;
               end else if (v == 2) err = ERR_SYSEX;
            end
            default: begin
               remain = remain - 1;
               if (remain == 0) ph = PH_DELTA;
            end
         endcase
         if (err < 0 && last && !stopped) begin
            case (ph)
               PH_DELTA:      if (len_cnt != 0) err = ERR_DELTA;
               PH_META_TYPE:  err = ERR_META_INC;
               PH_META_LEN, PH_META_DATA: err = ERR_META_LEN;
               PH_SYSEX_LEN, PH_SYSEX_DATA: err = ERR_SYSEX;
               PH_CHAN_DATA:  err = ERR_CHANNEL;
               default: ;
            endcase
         end
      end
      if (err >= 0) begin
         failed_track = 1;
         r = '0; r.kind = KIND_ERROR; r.tick = abs_tick; r.error_code = 3'(err);
         expected_events = {expected_events, r};
         return;
      end
      if (last) clear_track();
      if (got) expected_events = {expected_events, r};
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit first = 0, input bit last = 0);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1; req_tdata <= b; req_tuser <= first; req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(b, first, last);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_vlq(input logic [27:0] n);
      logic [6:0] g[4];
      int k;
      k = 0;
      do begin
         g[k] = n[6:0]; n = n >> 7; k++;
      end while (n != 0 && k < 4);
      for (int i = k - 1; i >= 0; i--) send_byte({i != 0, g[i]});
   endtask

   task automatic send_meta(input logic [7:0] kind, input logic [7:0] p[$]);
      send_byte(8'hFF); send_byte(kind); send_vlq(28'(p.size()));
      foreach (p[i]) send_byte(p[i]);
   endtask

   task automatic random_event();
      int sel;
      logic [7:0] p[$];
      sel = $urandom_range(0, 19);
      send_vlq($urandom_range(0, 3) == 0 ? 28'($urandom) : 28'($urandom_range(0, 200)));
      case (sel)
         0, 1: begin
            p = '{8'($urandom), 8'($urandom), 8'($urandom)};
            if (p[0] == 0 && p[1] == 0) p[2] = 8'($urandom_range(1, 255));
            send_meta(8'h51, p);
         end
         2, 3: begin
            p = '{8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)), 8'($urandom),
                  8'($urandom)};
            p[0] = $urandom_range(0, 3) ? 8'($urandom_range(1, 255)) : p[0];
            p = p[0:$urandom_range(1, 3)];
            send_meta(8'h58, p);
         end
         4: begin
            p.delete();
            repeat ($urandom_range(0, 5)) p = {p, 8'($urandom)};
            send_meta(8'($urandom), p);
         end
         5, 6: begin
            send_byte($urandom_range(0, 1) ? 8'hF0 : 8'hF7);
            send_vlq($urandom_range(0, 6));
            repeat (remain) send_byte(8'($urandom));
         end
         default: begin
            if (run_status != 0 && $urandom_range(0, 1)) send_byte(8'($urandom_range(0, 127)));
            else send_byte(8'($urandom_range(8'h80, 8'hEF)));
            while (ph == PH_CHAN_DATA) send_byte(8'($urandom_range(0, 127)));
         end
      endcase
   endtask

   task automatic test_directed();
      logic [7:0] p[$];
      send_byte(8'h00, 1);
      p = '{8'h07, 8'hA1, 8'h20}; send_meta(8'h51, p);           // 500000 us
      send_byte(8'h81); send_byte(8'h00);
      p = '{8'h00, 8'h00, 8'h01}; send_meta(8'h51, p);           // fastest tempo
      send_byte(8'h7F);
      p = '{8'hFF, 8'hFF, 8'hFF}; send_meta(8'h51, p);
      send_byte(8'h00);
      p = '{8'h00, 8'h00, 8'h00}; send_meta(8'h51, p);           // zero tempo
      send_byte(8'h00);
      p = '{8'hFF, 8'h0A, 8'h18, 8'h08}; send_meta(8'h58, p);
      send_byte(8'h00);
      p = '{8'h03, 8'h0B}; send_meta(8'h58, p);                  // power too big
      send_byte(8'h00); send_byte(8'h90); send_byte(8'h3C); send_byte(8'h7F);
      send_byte(8'h00); send_byte(8'h40); send_byte(8'h00);      // running status
      send_byte(8'h00); send_byte(8'hC5); send_byte(8'h10);
      send_byte(8'h00); send_byte(8'hF0); send_byte(8'h01); send_byte(8'hF7);
      send_byte(8'h8F); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h7F);
      p.delete(); send_meta(8'h2F, p);                           // end of track
      send_byte(8'hAA); send_byte(8'h55, 0, 1);                  // ignored
      send_byte(8'h05); send_byte(8'hFF);                        // abandoned meta
      send_byte(8'h00, 1, 1);                                    // delta then end
   endtask

   task automatic test_random_tracks();
      int n;
      while (sent < 1500) begin
         send_byte(8'($urandom_range(0, 20)), 1);
         send_byte(8'hFF); send_byte(8'h51); send_byte(8'h03);
         send_byte(8'($urandom)); send_byte(8'($urandom)); send_byte(8'($urandom_range(1, 255)));
         n = $urandom_range(2, 25);
         repeat (n) random_event();
         if ($urandom_range(0, 2) == 0) begin
            send_byte(8'h00); send_byte(8'hFF); send_byte(8'h2F); send_byte(8'h00);
            send_byte(8'($urandom)); send_byte(8'($urandom), 0, 1);
         end else begin
            send_byte(8'h00); send_byte(8'hFF); send_byte(8'h2F); send_byte(8'h00, 0, 1);
         end
      end
   endtask

   task automatic test_backpressure();
      logic [7:0] p[$];
      // request a long hold-off; the receiver counts it out on its own
      hold_rsp = 1;
      send_byte(8'h00, 1);
      p = '{8'h01, 8'h00, 8'h00}; send_meta(8'h51, p);
      hold_rsp = 0;
      repeat (5) begin
         send_byte(8'h00); p = '{8'h04, 8'h02}; send_meta(8'h58, p);
      end
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'h2F); send_byte(8'h00, 0, 1);
   endtask

   task automatic test_error_tail();
      // one sticky error per run, taken last: a truncated meta, then dead bytes
      quiet = 1;
      send_byte(8'h00, 1); send_byte(8'hFF, 0, 1);
      repeat (10) send_byte(8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1));
   endtask

   // receiver stalls, plus a long hold-off while the sender fills the block
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            n = 0;
            while (n < 300) begin
               @(negedge clock); n++;
            end
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end else begin
            rsp_tready <= 1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      result_type got, want;
      cycles++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '0;
         got.kind = rsp_tuser;
         got.tick = rsp_tdata[31:0];
         got.tempo_us = rsp_tdata[55:32];
         got.bpm_fixed = rsp_tdata[89:56];
         got.numerator = rsp_tdata[97:90];
         got.denominator = rsp_tdata[108:98];
         got.error_code = rsp_tdata[111:109];
         received++;
         kind_seen[got.kind]++;
         if (expected_events.size() == 0) report("unexpected result transfer");
         else begin
            want = expected_events.pop_front();
            if (got.kind != want.kind)
               report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.tick != want.tick)
               report($sformatf("tick %0d, want %0d", got.tick, want.tick));
            if (got.tempo_us != want.tempo_us)
               report($sformatf("tempo %0d, want %0d", got.tempo_us,
                                want.tempo_us));
            if (got.bpm_fixed != want.bpm_fixed)
               report($sformatf("bpm %0d, want %0d", got.bpm_fixed, want.bpm_fixed));
            if (got.numerator != want.numerator)
               report($sformatf("numerator %0d, want %0d", got.numerator, want.numerator));
            if (got.denominator != want.denominator)
               report($sformatf("denominator %0d, want %0d", got.denominator,
                                want.denominator));
            if (got.error_code != want.error_code)
               report($sformatf("error code %0d, want %0d", got.error_code,
                                want.error_code));
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int guard;
      clear_track();
      meta_code = 0;
      failed_track = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_backpressure();
      test_random_tracks();
      test_error_tail();
      req_tvalid <= 0;
      guard = 0;
      while (expected_events.size() != 0 && guard < 20000) begin
         @(negedge clock); guard++;
      end
      repeat (60) @(negedge clock);
      if (expected_events.size() != 0) report("results still outstanding at end");
      $display("%0d bytes sent, %0d results checked: tempo %0d, meter %0d, error %0d, eot %0d",
               sent, received, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      $display("covered running status, sysex, meta edge cases, long stall and sticky error");
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
